// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SPMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SPMQ_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SPMQ_ASSERT(lbl, clk, rst_n, prop, msg)

`define SPMQ_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- rtl/spmq_pkg.sv -----
// ----------------------------------------------------------------------------
// spmq_pkg
// Command, status and register codes and shared types of the priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spmq_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_EMPTY    = 2'd2;
    localparam logic [1:0] STS_BAD_PRIO = 2'd3;

    localparam logic [0:0] REG_NUM_LEVELS   = 1'b0;
    localparam logic [3:0] NUM_LEVELS_RESET = 4'd8;

    typedef struct packed {
        logic push;
        logic pop;
    } lvl_op_t;

    typedef struct packed {
        logic top_found;
        logic push_full;
    } lvl_flags_t;

endpackage

`default_nettype wire

// ----- rtl/spmq_ram.sv -----
// ----------------------------------------------------------------------------
// spmq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module spmq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/spmq_level_ctrl.sv -----
// ----------------------------------------------------------------------------
// spmq_level_ctrl
// Per-level ring pointers and fill counts, top-level search and count sum.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spmq_level_ctrl
    import spmq_pkg::*;
#(
    parameter int MAX_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16,
    parameter int LVL_W       = 3,
    parameter int PTR_W       = 4,
    parameter int FILL_W      = 5,
    parameter int SUM_W       = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [3:0]       num_levels,
    input  wire lvl_op_t          op,
    input  wire logic [LVL_W-1:0] push_lvl,
    input  wire logic [LVL_W-1:0] query_lvl,
    output lvl_flags_t            flags,
    output logic      [LVL_W-1:0] top_lvl,
    output logic      [PTR_W-1:0] top_head,
    output logic      [PTR_W-1:0] push_tail,
    output logic      [FILL_W-1:0] query_fill,
    output logic      [SUM_W-1:0] active_sum
);

    logic [PTR_W-1:0]  head_reg [MAX_LEVELS];
    logic [PTR_W-1:0]  tail_reg [MAX_LEVELS];
    logic [FILL_W-1:0] fill_reg [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] active;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            active[l] = int'(num_levels) > l;
        end
    end

    always_comb
    begin
        flags.top_found = 1'b0;
        flags.push_full = fill_reg[push_lvl] == FILL_W'(LEVEL_DEPTH);
        top_lvl         = '0;
        active_sum      = '0;
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            if (active[l] && (fill_reg[l] != '0))
            begin
                flags.top_found = 1'b1;
                top_lvl         = LVL_W'(l);
            end
            if (active[l])
            begin
                active_sum = active_sum + SUM_W'(fill_reg[l]);
            end
        end
    end

    assign top_head        = head_reg[top_lvl];
    assign push_tail       = tail_reg[push_lvl];
    assign query_fill      = fill_reg[query_lvl];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                fill_reg[l] <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                if (op.push && (push_lvl == LVL_W'(l)))
                begin
                    tail_reg[l] <= ring_next(tail_reg[l]);
                    fill_reg[l] <= fill_reg[l] + FILL_W'(1);
                end
                else if (op.pop && (top_lvl == LVL_W'(l)))
                begin
                    head_reg[l] <= ring_next(head_reg[l]);
                    fill_reg[l] <= fill_reg[l] - FILL_W'(1);
                end
            end
        end
    end

    `SPMQ_NEVER(a_push_full, clk, rst_n, op.push && flags.push_full, "push into a full level")
    `SPMQ_NEVER(a_pop_empty, clk, rst_n, op.pop && !flags.top_found, "pop with no level holding data")
    `SPMQ_NEVER(a_push_pop, clk, rst_n, op.push && op.pop, "push and pop in the same cycle")

endmodule

`default_nettype wire

// ----- rtl/strict_priority_multi_queue.sv -----
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// Multi-level FIFO task queue that always serves the highest non-empty level.
// ----------------------------------------------------------------------------
// Commands arrive on the input channel (in_valid/in_stall) with command,
// task_id and priority_req. Each transaction yields exactly one result on the
// output channel (out_valid/out_stall) that describes the store after the
// command: front task and level, total and per-level counts, and a status.
// The number of active levels is set through the APB register at address 0.
// One command is processed at a time: accept, update of pointers and task
// memory write, front read from the task memory, and result capture, so a
// new command is not taken until the result of the last one is captured.
// The registered read of the task memory and the update that must precede
// the front lookup set this sequence.
// A result held by a stalled receiver stays in the output register; the next
// command is accepted meanwhile, but its result waits in the capture step.
// Reset empties every level, sets the level count to 8 and drops any pending
// result; task memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module strict_priority_multi_queue
    import spmq_pkg::*;
#(
    parameter int MAX_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] task_id,
    input  wire logic [3:0]  priority_req,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             front_valid,
    output logic [15:0]      front_task_id,
    output logic [3:0]       front_priority,
    output logic [7:0]       total_count,
    output logic [4:0]       level_count,
    output logic [1:0]       status
);

    localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
    localparam int SUM_W  = $clog2(MAX_LEVELS * LEVEL_DEPTH + 1);
    localparam int DEPTH  = MAX_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOOK = 2'd2;
    localparam logic [1:0] S_CAPT = 2'd3;

    logic [1:0]  state_reg;
    logic [3:0]  num_levels_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] tid_reg;
    logic [3:0]  pri_reg;
    logic [1:0]  sts_reg;
    logic        found_reg;
    logic [3:0]  fpri_reg;
    logic [7:0]  sum_reg;
    logic [4:0]  lcount_reg;

    logic        out_valid_reg;
    logic        front_valid_reg;
    logic [15:0] front_task_id_reg;
    logic [3:0]  front_priority_reg;
    logic [7:0]  total_count_reg;
    logic [4:0]  level_count_reg;
    logic [1:0]  status_reg;

    logic              cfg_write;
    logic              in_accept;
    logic              out_free;
    logic              pri_ok;
    logic [4:0]        pri_m1;
    logic [LVL_W-1:0]  pri_lvl;
    lvl_op_t           op;
    lvl_flags_t        flags;
    logic [LVL_W-1:0]  top_lvl;
    logic [PTR_W-1:0]  top_head;
    logic [PTR_W-1:0]  push_tail;
    logic [FILL_W-1:0] query_fill;
    logic [SUM_W-1:0]  active_sum;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ID_BITS-1:0] ram_rdata;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] ptr);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(ptr);
        return a;
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2:2] == REG_NUM_LEVELS) ? {28'd0, num_levels_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_levels_reg <= NUM_LEVELS_RESET;
        end
        else if (cfg_write && (paddr[2:2] == REG_NUM_LEVELS))
        begin
            num_levels_reg <= pwdata[3:0];
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign pri_ok  = (pri_reg != 4'd0) && (pri_reg <= num_levels_reg)
                     && (int'(pri_reg) <= MAX_LEVELS);
    assign pri_m1  = {1'b0, pri_reg} - 5'd1;
    assign pri_lvl = LVL_W'(pri_m1);

    always_comb
    begin
        op.push = 1'b0;
        op.pop  = 1'b0;
        if (state_reg == S_EXEC)
        begin
            if (cmd_reg == CMD_ADD)
            begin
                op.push = pri_ok && !flags.push_full;
            end
            else if (cmd_reg == CMD_REMOVE)
            begin
                op.pop = flags.top_found;
            end
        end
    end

    assign ram_we    = op.push;
    assign ram_waddr = slot_addr(pri_lvl, push_tail);
    assign ram_re    = (state_reg == S_LOOK) && flags.top_found;
    assign ram_raddr = slot_addr(top_lvl, top_head);

    spmq_level_ctrl #(
        .MAX_LEVELS  (MAX_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .LVL_W       (LVL_W),
        .PTR_W       (PTR_W),
        .FILL_W      (FILL_W),
        .SUM_W       (SUM_W)
    ) u_levels (
        .clk        (clk),
        .rst_n      (rst_n),
        .num_levels (num_levels_reg),
        .op         (op),
        .push_lvl   (pri_lvl),
        .query_lvl  (pri_lvl),
        .flags      (flags),
        .top_lvl    (top_lvl),
        .top_head   (top_head),
        .push_tail  (push_tail),
        .query_fill (query_fill),
        .active_sum (active_sum)
    );

    spmq_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_task_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ID_BITS'(tid_reg)),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_LOOK;
                end
                S_LOOK:
                begin
                    state_reg <= S_CAPT;
                end
                S_CAPT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= command;
            tid_reg <= task_id;
            pri_reg <= priority_req;
        end
        if (state_reg == S_EXEC)
        begin
            priority if (cmd_reg == CMD_ADD && !pri_ok)
            begin
                sts_reg <= STS_BAD_PRIO;
            end
            else if (cmd_reg == CMD_ADD && flags.push_full)
            begin
                sts_reg <= STS_FULL;
            end
            else if (cmd_reg == CMD_REMOVE && !flags.top_found)
            begin
                sts_reg <= STS_EMPTY;
            end
            else
            begin
                sts_reg <= STS_OK;
            end
        end
        if (state_reg == S_LOOK)
        begin
            found_reg  <= flags.top_found;
            fpri_reg   <= flags.top_found ? 4'(top_lvl) + 4'd1 : 4'd0;
            sum_reg    <= 8'(active_sum);
            lcount_reg <= pri_ok ? 5'(query_fill) : 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_CAPT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_CAPT) && out_free)
        begin
            front_valid_reg    <= found_reg;
            front_task_id_reg  <= found_reg ? 16'(ram_rdata) : 16'd0;
            front_priority_reg <= fpri_reg;
            total_count_reg    <= sum_reg;
            level_count_reg    <= lcount_reg;
            status_reg         <= sts_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign front_valid    = front_valid_reg;
    assign front_task_id  = front_task_id_reg;
    assign front_priority = front_priority_reg;
    assign total_count    = total_count_reg;
    assign level_count    = level_count_reg;
    assign status         = status_reg;

    `SPMQ_ASSERT(a_accept_exec, clk, rst_n, in_accept |=> (state_reg == S_EXEC), "accepted command did not start")
    `SPMQ_NEVER(a_we_state, clk, rst_n, ram_we && !((state_reg == S_EXEC) && (cmd_reg == CMD_ADD)), "task memory written outside an add")
    `SPMQ_NEVER(a_front_empty, clk, rst_n, out_valid && !front_valid && ((front_task_id != 16'd0) || (front_priority != 4'd0)), "empty result carries a front task")
    `SPMQ_NEVER(a_front_prio, clk, rst_n, out_valid && front_valid && (front_priority == 4'd0) && (MAX_LEVELS < 16), "front task without a level")

endmodule

`default_nettype wire

// ----- dv/strict_priority_multi_queue_test.sv -----
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_test
// Self-checking testbench for the strict-priority multi-level task queue.
// A clocked driver sends command transactions taken from a queue that the
// stimulus process fills. A clocked monitor compares every result transaction,
// field by field, with the store state that the predictor in this file works
// out. The run starts with a directed sequence and goes on to random bursts
// under a range of level counts set through the APB register. Sender and
// receiver stall at random with a different mix per part, but not in the last.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue_test;
    import spmq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEVELS     = 8;
    localparam int LEVEL_DEPTH    = 16;
    localparam int SEGMENT_ITEMS  = 100;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PRINT_LIMIT    = 100;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] task_id;
        logic [3:0]  prio;
    } queue_cmd_t;

    typedef struct packed {
        logic        front_valid;
        logic [15:0] front_task_id;
        logic [3:0]  front_priority;
        logic [7:0]  total_count;
        logic [4:0]  level_count;
        logic [1:0]  status;
    } queue_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_QUERY;
    logic [15:0] task_id = '0;
    logic [3:0]  priority_req = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        front_valid;
    logic [15:0] front_task_id;
    logic [3:0]  front_priority;
    logic [7:0]  total_count;
    logic [4:0]  level_count;
    logic [1:0]  status;

    queue_cmd_t  pending_cmds[$];
    queue_view_t predicted_views[$];
    queue_cmd_t  in_flight;
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    logic [15:0] ids_held[MAX_LEVELS][LEVEL_DEPTH];
    int          head_pos[MAX_LEVELS];
    int          tail_pos[MAX_LEVELS];
    int          fill[MAX_LEVELS];
    logic [3:0]  levels_cfg = NUM_LEVELS_RESET;

    int          level_plan[14] = '{8, 1, 15, 4, 0, 2, 8, 3, 12, 6, 1, 5, 7, 8};

    strict_priority_multi_queue u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .task_id        (task_id),
        .priority_req   (priority_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .front_valid    (front_valid),
        .front_task_id  (front_task_id),
        .front_priority (front_priority),
        .total_count    (total_count),
        .level_count    (level_count),
        .status         (status)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int active_levels();
        return (levels_cfg > MAX_LEVELS) ? MAX_LEVELS : int'(levels_cfg);
    endfunction

    function automatic int highest_busy_level(input int act);
        for (int lvl = act - 1; lvl >= 0; lvl--)
            if (fill[lvl] != 0)
                return lvl;
        return -1;
    endfunction

    function automatic queue_view_t apply_command(input queue_cmd_t c);
        queue_view_t v;
        int act;
        int lvl;
        int top;
        int sum;
        act = active_levels();
        v = '0;
        v.status = STS_OK;
        if (c.command == CMD_ADD) begin
            if (c.prio == 0 || c.prio > act) begin
                v.status = STS_BAD_PRIO;
            end else if (fill[c.prio - 1] >= LEVEL_DEPTH) begin
                v.status = STS_FULL;
            end else begin
                lvl = int'(c.prio) - 1;
                ids_held[lvl][tail_pos[lvl]] = c.task_id;
                tail_pos[lvl] = (tail_pos[lvl] + 1) % LEVEL_DEPTH;
                fill[lvl]++;
            end
        end else if (c.command == CMD_REMOVE) begin
            top = highest_busy_level(act);
            if (top < 0) begin
                v.status = STS_EMPTY;
            end else begin
                head_pos[top] = (head_pos[top] + 1) % LEVEL_DEPTH;
                fill[top]--;
            end
        end
        top = highest_busy_level(act);
        sum = 0;
        for (int i = 0; i < act; i++)
            sum += fill[i];
        if (top >= 0) begin
            v.front_valid = 1'b1;
            v.front_task_id = ids_held[top][head_pos[top]];
            v.front_priority = 4'(top + 1);
        end
        v.total_count = 8'(sum);
        if (c.prio != 0 && c.prio <= act)
            v.level_count = 5'(fill[c.prio - 1]);
        return v;
    endfunction

    task automatic check_result(input queue_view_t exp_v);
        if (front_valid !== exp_v.front_valid)
            report_mismatch($sformatf("front_valid %0b, expected %0b",
                                      front_valid, exp_v.front_valid));
        if (front_task_id !== exp_v.front_task_id)
            report_mismatch($sformatf("front_task_id %h, expected %h",
                                      front_task_id, exp_v.front_task_id));
        if (front_priority !== exp_v.front_priority)
            report_mismatch($sformatf("front_priority %0d, expected %0d",
                                      front_priority, exp_v.front_priority));
        if (total_count !== exp_v.total_count)
            report_mismatch($sformatf("total_count %0d, expected %0d",
                                      total_count, exp_v.total_count));
        if (level_count !== exp_v.level_count)
            report_mismatch($sformatf("level_count %0d, expected %0d",
                                      level_count, exp_v.level_count));
        if (status !== exp_v.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, exp_v.status));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                predicted_views.push_back(apply_command(in_flight));
            if (!in_valid || !in_stall) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    command <= in_flight.command;
                    task_id <= in_flight.task_id;
                    priority_req <= in_flight.prio;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (predicted_views.size() == 0)
                    report_mismatch("result transaction with no command outstanding");
                else
                    check_result(predicted_views.pop_front());
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic push_cmd(input logic [1:0] cmd, input logic [15:0] id,
                            input logic [3:0] prio);
        queue_cmd_t c;
        c.command = cmd;
        c.task_id = id;
        c.prio = prio;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_for_drain();
        int waited;
        waited = 0;
        while ((pending_cmds.size() != 0 || in_valid || predicted_views.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (predicted_views.size() != 0 || pending_cmds.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_views.size()));
    endtask

    task automatic write_levels(input logic [3:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_NUM_LEVELS, 2'b00};
        pwdata <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        levels_cfg = value;
    endtask

    task automatic queue_random_burst(input int count);
        queue_cmd_t c;
        int act;
        int left;
        int run_len;
        int add_pct;
        int focus;
        int pick;
        act = active_levels();
        left = count;
        while (left > 0) begin
            run_len = $urandom_range(8, 40);
            case ($urandom_range(2))
                0:       add_pct = 85;
                1:       add_pct = 50;
                default: add_pct = 15;
            endcase
            focus = $urandom_range(1, (act == 0) ? 1 : act);
            for (int k = 0; k < run_len && left > 0; k++) begin
                pick = $urandom_range(99);
                if (pick < add_pct) begin
                    c.command = CMD_ADD;
                end else begin
                    pick = $urandom_range(99);
                    c.command = (pick < 75) ? CMD_REMOVE : (pick < 95) ? CMD_QUERY : CMD_UNUSED;
                end
                c.task_id = 16'($urandom());
                pick = $urandom_range(99);
                if (pick < 45)
                    c.prio = 4'(focus);
                else if (pick < 85)
                    c.prio = 4'($urandom_range(1, (act == 0) ? MAX_LEVELS : act));
                else if (pick < 93)
                    c.prio = 4'd0;
                else
                    c.prio = 4'($urandom_range(act + 1, 15));
                pending_cmds.push_back(c);
                left--;
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("** strict_priority_multi_queue: FAILED **");
        $finish;
    end

    initial begin
        for (int l = 0; l < MAX_LEVELS; l++) begin
            head_pos[l] = 0;
            tail_pos[l] = 0;
            fill[l] = 0;
        end
        send_idle_pct = 12;
        stall_pct = 86;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        push_cmd(CMD_REMOVE, 16'h1111, 4'd0);
        push_cmd(CMD_QUERY, 16'h2222, 4'd15);
        push_cmd(CMD_UNUSED, 16'h3333, 4'd3);
        push_cmd(CMD_ADD, 16'h1234, 4'd0);
        push_cmd(CMD_ADD, 16'h4321, 4'd9);
        push_cmd(CMD_ADD, 16'hFFFF, 4'd15);
        push_cmd(CMD_ADD, 16'hFFFF, 4'd8);
        push_cmd(CMD_ADD, 16'h0000, 4'd1);
        for (int i = 1; i < LEVEL_DEPTH; i++)
            push_cmd(CMD_ADD, 16'(i), 4'd1);
        push_cmd(CMD_ADD, 16'hA5A5, 4'd1);
        push_cmd(CMD_QUERY, 16'h0000, 4'd1);
        push_cmd(CMD_REMOVE, 16'h0000, 4'd8);
        push_cmd(CMD_REMOVE, 16'h0000, 4'd1);

        for (int seg = 0; seg < 14; seg++) begin
            wait_for_drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_levels(4'(level_plan[seg]));
            if (seg < 5) begin
                send_idle_pct = 12;
                stall_pct = 86;
            end else if (seg < 10) begin
                send_idle_pct = 86;
                stall_pct = 12;
            end else begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            queue_random_burst(SEGMENT_ITEMS);
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** strict_priority_multi_queue: PASSED **");
        else
            $display("** strict_priority_multi_queue: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/spmq_pkg.sv
rtl/spmq_ram.sv
rtl/spmq_level_ctrl.sv
rtl/strict_priority_multi_queue.sv
dv/strict_priority_multi_queue_test.sv
